// ===== hdl/priority_ready_queue_core_defines.svh =====
// Assertion macros shared by the priority ready queue RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRQ_ASSERT_NEXT(lbl, clk, rst_n, cond, expct, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) else $error(msg);
`else
`define PRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRQ_ASSERT_NEXT(lbl, clk, rst_n, cond, expct, msg)
`endif
`endif

// ===== hdl/prq_pkg.sv =====
// Package for the priority ready queue: field widths, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package prq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_ID_BITS     = 8;
    localparam int unsigned DEF_PRIO_BITS   = 8;

    localparam int unsigned MODE_W       = 2;
    localparam int unsigned FIELD_ID_W   = 8;
    localparam int unsigned FIELD_PRIO_W = 8;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned OCC_W        = 5;

    localparam int unsigned IN_MODE_LSB  = 0;
    localparam int unsigned IN_ID_LSB    = IN_MODE_LSB + MODE_W;
    localparam int unsigned IN_PRIO_LSB  = IN_ID_LSB + FIELD_ID_W;
    localparam int unsigned IN_DATA_W    = 24;

    localparam int unsigned OUT_STAT_LSB = 0;
    localparam int unsigned OUT_ID_LSB   = OUT_STAT_LSB + STATUS_W;
    localparam int unsigned OUT_PRIO_LSB = OUT_ID_LSB + FIELD_ID_W;
    localparam int unsigned OUT_OCC_LSB  = OUT_PRIO_LSB + FIELD_PRIO_W;
    localparam int unsigned OUT_DATA_W   = 24;

    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REM = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic                op_load;
        logic                rd_en;
        logic                wr_en;
        logic                wr_new;
        logic                res_clear;
        logic                res_take;
        logic                res_status_load;
        logic [STATUS_W-1:0] res_status;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              full;
        logic              id_match;
        logic              prio_ge;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== hdl/priority_ready_queue_core.sv =====
// Priority ready queue: sorted, stable insert; dequeue head; remove by pid.
// A full, empty or no-op item goes straight from decode to its result; a dequeue or
// remove walks all filled entries, and an enqueue walks down from the tail to its slot.
// The walk visits one entry slot a cycle; a new item is taken only once the last is done.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, i_rst_n low) empties the queue and drops any pending result.
`default_nettype none
module priority_ready_queue_core #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned ID_BITS     = prq_pkg::DEF_ID_BITS,
    parameter int unsigned PRIO_BITS   = prq_pkg::DEF_PRIO_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [prq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // mode, proc_id, prio
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [prq_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // status, out_id, out_prio, occupancy
);
    import prq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [CW-1:0] w_count;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    prq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .i_count    (w_count),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr)
    );

    prq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .o_stat    (w_stat),
        .o_count   (w_count),
        .o_m_tdata (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/prq_dpath.sv =====
// Datapath of the priority ready queue: entry memory, fill count,
// operation, result and output registers. Uses prq_pkg and the defines header.
`default_nettype none
`include "priority_ready_queue_core_defines.svh"
module prq_dpath #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned ID_BITS     = prq_pkg::DEF_ID_BITS,
    parameter int unsigned PRIO_BITS   = prq_pkg::DEF_PRIO_BITS,
    parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
    parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [prq_pkg::IN_DATA_W-1:0]   i_s_tdata,  // mode, proc_id, prio
    input  wire prq_pkg::t_dp_cmd                i_cmd,
    input  wire logic [AW-1:0]                   i_rd_addr,
    input  wire logic [AW-1:0]                   i_wr_addr,
    output prq_pkg::t_dp_stat                    o_stat,
    output logic [CW-1:0]                        o_count,
    output logic [prq_pkg::OUT_DATA_W-1:0]       o_m_tdata   // status, out_id, out_prio, occupancy
);
    import prq_pkg::*;

    localparam int unsigned EW = ID_BITS + PRIO_BITS;

    logic [EW-1:0]        r_mem [QUEUE_DEPTH];
    logic [EW-1:0]        r_rd_data;
    logic [EW-1:0]        w_wr_data;
    logic [CW-1:0]        r_count;
    logic [MODE_W-1:0]    r_op_mode;
    logic [ID_BITS-1:0]   r_op_id;
    logic [PRIO_BITS-1:0] r_op_prio;
    logic [STATUS_W-1:0]  r_res_status;
    logic [ID_BITS-1:0]   r_res_id;
    logic [PRIO_BITS-1:0] r_res_prio;
    logic [STATUS_W-1:0]  r_out_status;
    logic [FIELD_ID_W-1:0]   r_out_id;
    logic [FIELD_PRIO_W-1:0] r_out_prio;
    logic [OCC_W-1:0]     r_out_occ;

    assign w_wr_data = i_cmd.wr_new ? {r_op_id, r_op_prio} : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_load) begin
            r_op_mode <= i_s_tdata[IN_MODE_LSB +: MODE_W];
            r_op_id   <= ID_BITS'(i_s_tdata[IN_ID_LSB +: FIELD_ID_W]);
            r_op_prio <= PRIO_BITS'(i_s_tdata[IN_PRIO_LSB +: FIELD_PRIO_W]);
        end
        if (i_cmd.res_clear) begin
            r_res_id   <= '0;
            r_res_prio <= '0;
        end else if (i_cmd.res_take) begin
            r_res_id   <= r_rd_data[EW-1:PRIO_BITS];
            r_res_prio <= r_rd_data[PRIO_BITS-1:0];
        end
        if (i_cmd.res_status_load) begin
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= FIELD_ID_W'(r_res_id);
            r_out_prio   <= FIELD_PRIO_W'(r_res_prio);
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    always_comb begin
        o_stat.mode     = r_op_mode;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
        o_stat.id_match = (r_rd_data[EW-1:PRIO_BITS] == r_op_id);
        o_stat.prio_ge  = (r_rd_data[PRIO_BITS-1:0] >= r_op_prio);
    end

    assign o_count = r_count;
    assign o_m_tdata = {
        {(OUT_DATA_W - OUT_OCC_LSB - OCC_W){1'b0}},
        r_out_occ, r_out_prio, r_out_id, r_out_status
    };

    `PRQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH), "fill count past depth")
    `PRQ_ASSERT(a_inc_not_full, i_clk, i_rst_n, i_cmd.cnt_inc |-> !o_stat.full, "insert into full queue")
    `PRQ_ASSERT(a_dec_not_empty, i_clk, i_rst_n, i_cmd.cnt_dec |-> !o_stat.empty, "remove from empty queue")

endmodule
`default_nettype wire

// ===== hdl/prq_ctrl.sv =====
// Controller of the priority ready queue: decodes the operation and walks
// the entry memory one slot a cycle. Uses prq_pkg and the defines header.
`default_nettype none
`include "priority_ready_queue_core_defines.svh"
module prq_ctrl #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
    parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire prq_pkg::t_dp_stat i_stat,
    input  wire logic [CW-1:0]     i_count,
    output prq_pkg::t_dp_cmd       o_cmd,
    output logic [AW-1:0]          o_rd_addr,
    output logic [AW-1:0]          o_wr_addr
);
    import prq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ,
        S_DEL,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic          r_out_valid, n_out_valid;
    logic          w_hit;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_rd_addr   = '0;
        o_wr_addr   = '0;
        w_hit       = !r_found && ((i_stat.mode == MODE_DEQ) || i_stat.id_match);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op_load = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_clear = 1'b1;
                n_found         = 1'b0;
                n_idx           = '0;
                case (i_stat.mode)
                    MODE_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.res_status_load = 1'b1;
                            o_cmd.res_status      = ST_FULL;
                            n_state               = S_DONE;
                        end else begin
                            n_idx   = i_count;
                            n_state = S_ENQ;
                            if (!i_stat.empty) begin
                                o_cmd.rd_en = 1'b1;
                                o_rd_addr   = AW'(i_count - 1'b1);
                            end
                        end
                    end
                    MODE_DEQ, MODE_REM: begin
                        if (i_stat.empty) begin
                            o_cmd.res_status_load = 1'b1;
                            o_cmd.res_status      = (i_stat.mode == MODE_DEQ) ?
                                                    ST_EMPTY : ST_NOTFOUND;
                            n_state               = S_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_DEL;
                        end
                    end
                    default: begin
                        o_cmd.res_status_load = 1'b1;
                        o_cmd.res_status      = ST_OK;
                        n_state               = S_DONE;
                    end
                endcase
            end
            S_ENQ: begin
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = AW'(r_idx);
                if ((r_idx == '0) || i_stat.prio_ge) begin
                    o_cmd.wr_new          = 1'b1;
                    o_cmd.cnt_inc         = 1'b1;
                    o_cmd.res_status_load = 1'b1;
                    o_cmd.res_status      = ST_OK;
                    n_state               = S_DONE;
                end else begin
                    n_idx = r_idx - 1'b1;
                    if (r_idx > CW'(1)) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = AW'(r_idx - CW'(2));
                    end
                end
            end
            S_DEL: begin
                if (w_hit) begin
                    o_cmd.res_take = 1'b1;
                    n_found        = 1'b1;
                end
                if (r_found) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = AW'(r_idx - 1'b1);
                end
                if ((r_idx + 1'b1) < i_count) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(r_idx + 1'b1);
                    n_idx       = r_idx + 1'b1;
                end else begin
                    o_cmd.res_status_load = 1'b1;
                    o_cmd.res_status      = (r_found || w_hit) ? ST_OK : ST_NOTFOUND;
                    o_cmd.cnt_dec         = r_found || w_hit;
                    n_state               = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    `PRQ_ASSERT(a_rd_in_fill, i_clk, i_rst_n, o_cmd.rd_en |-> (CW'(o_rd_addr) < i_count), "read past fill")
    `PRQ_ASSERT(a_no_rw_clash, i_clk, i_rst_n, (o_cmd.rd_en && o_cmd.wr_en) |-> (o_rd_addr != o_wr_addr), "read and write same slot")
    `PRQ_ASSERT_NEXT(a_walk_holds, i_clk, i_rst_n, (r_state == S_DEL) && !o_cmd.res_status_load, r_state == S_DEL, "walk ended early")

endmodule
`default_nettype wire
